/* hw/rtl/jst_pkg.sv */
// Shared types, codes and lookup functions for the JSON stream tokenizer.
package jst_pkg;

  localparam int MAX_NEST_DEF = 128;
  localparam int MAXRES = 4;
  localparam int QDEPTH = 2;
  localparam logic [7:0] MAX_DEPTH_RST = 8'd128;

  typedef enum logic [3:0] {
    EV_OBJ_OPEN  = 4'd0,
    EV_OBJ_CLOSE = 4'd1,
    EV_ARR_OPEN  = 4'd2,
    EV_ARR_CLOSE = 4'd3,
    EV_KEY_BYTE  = 4'd4,
    EV_KEY_END   = 4'd5,
    EV_STR_BYTE  = 4'd6,
    EV_STR_END   = 4'd7,
    EV_NUM_BYTE  = 4'd8,
    EV_NUM_END   = 4'd9,
    EV_TRUE      = 4'd10,
    EV_FALSE     = 4'd11,
    EV_NULL      = 4'd12,
    EV_DONE      = 4'd13,
    EV_ERROR     = 4'd14
  } ev_kind_t;

  typedef enum logic [3:0] {
    ER_DEPTH     = 4'd0,
    ER_EARLY_END = 4'd1,
    ER_LITERAL   = 4'd2,
    ER_BAD_START = 4'd3,
    ER_BAD_HEX   = 4'd4,
    ER_BAD_ESC   = 4'd5,
    ER_UNTERM    = 4'd6,
    ER_TRUNC_U   = 4'd7,
    ER_KEY       = 4'd8,
    ER_NO_COLON  = 4'd9,
    ER_ARR_SEP   = 4'd10,
    ER_OBJ_SEP   = 4'd11,
    ER_TRAILING  = 4'd12
  } err_code_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic [7:0] level;
    err_code_t  code;
  } event_t;

  typedef struct packed {
    event_t [MAXRES-1:0] ev;
    logic [2:0]          cnt;
  } bundle_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: case (pos)
        3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      2'd1: case (pos)
        3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
        default: c = 8'h00;
      endcase
      default: case (pos)
        3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
      endcase
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
           c == "+" || c == "-";
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (c >= "a" && c <= "f") begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

/* hw/rtl/json_stream_tokenizer.sv */
// Top level of the streaming JSON tokenizer.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid / in_stall     | text_byte, byte_valid, end_of_text
//  out     | out_valid / out_stall   | event_kind, data_byte, nesting_level,
//          |                         | error_code, last_of_run
//  cfg     | cfg_valid / cfg_ready   | cfg_max_depth
//
// One input item is taken per cycle while the two-entry bundle queue has room.
// Each item yields 0 to 4 events; the serializer sends one event per cycle while
// out_stall is low, and an item with no events is never put in the queue.
// Synchronous reset clears parse state, queue and serializer; the nesting stack
// needs no clearing. Output stall backs up into the queue and then into in_stall.
module json_stream_tokenizer #(
  parameter int MAX_NEST = jst_pkg::MAX_NEST_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       byte_valid,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] event_kind,
  output logic [7:0] data_byte,
  output logic [7:0] nesting_level,
  output logic [3:0] error_code,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_depth
);
  import jst_pkg::*;

  logic [7:0] depth_reg;
  logic       q_full, q_push, q_pop, q_nonempty;
  bundle_t    q_wdata, q_rdata;
  event_t     ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) depth_reg <= MAX_DEPTH_RST;
    else if (cfg_valid && cfg_ready) depth_reg <= cfg_max_depth;
  end

  jst_front #(.MAX_NEST(MAX_NEST)) u_front (
    .clk, .rst, .in_valid, .in_stall, .text_byte, .byte_valid, .end_of_text,
    .max_depth(depth_reg), .q_full, .q_push, .q_data(q_wdata)
  );

  jst_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .nonempty(q_nonempty), .rdata(q_rdata)
  );

  jst_back u_back (
    .clk, .rst, .q_nonempty, .q_data(q_rdata), .q_pop, .out_valid, .out_stall,
    .ev, .last(last_of_run)
  );

  assign event_kind    = ev.kind;
  assign data_byte     = ev.data;
  assign nesting_level = ev.level;
  assign error_code    = ev.code;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("queue written while full");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_ERROR) |-> last_of_run)
    else $error("error event not last of its item");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != EV_ERROR) |-> error_code == ER_DEPTH)
    else $error("error code set on non-error event");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |-> q_full)
    else $error("input stalled with queue room");

endmodule

/* hw/rtl/jst_front.sv */
// Front end: accepts bytes, runs the parse state and nesting stack, builds event bundles.
module jst_front #(
  parameter int MAX_NEST = jst_pkg::MAX_NEST_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       text_byte,
  input  logic             byte_valid,
  input  logic             end_of_text,
  input  logic [7:0]       max_depth,
  input  logic             q_full,
  output logic             q_push,
  output jst_pkg::bundle_t q_data
);
  import jst_pkg::*;

  localparam int SLOTS = MAX_NEST + 1;
  localparam int LVL_W = $clog2(MAX_NEST + 2);
  localparam int CW = (LVL_W > 8) ? LVL_W : 8;

  typedef enum logic [3:0] {
    MD_TOP, MD_VALUE, MD_ARR_FIRST, MD_OBJ_FIRST, MD_KEY_NEXT, MD_STR,
    MD_ESC, MD_HEX, MD_COLON, MD_NUM, MD_LIT, MD_AFTER, MD_DONE, MD_ERR
  } mode_t;

  mode_t            mode, mode_next;
  logic [SLOTS-1:0] stk;
  logic [LVL_W-1:0] level, level_next;
  logic [15:0]      esc_code, esc_code_next;
  logic [2:0]       hex_count, hex_count_next;
  logic [1:0]       lit_kind, lit_kind_next;
  logic [2:0]       lit_pos, lit_pos_next;
  logic             in_key, in_key_next;
  logic             do_push, do_pop, push_kind;
  bundle_t          bnd;
  logic             accept;

  function automatic bundle_t add_ev(bundle_t b, ev_kind_t k, logic [7:0] d,
                                     logic [LVL_W-1:0] l, err_code_t c);
    bundle_t r;
    logic [CW-1:0] lx;
    r = b;
    lx = CW'(l);
    if (b.cnt < 3'(MAXRES)) begin
      r.ev[b.cnt[1:0]] = '{kind: k, data: d, level: lx[7:0], code: c};
      r.cnt = b.cnt + 3'd1;
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [CW-1:0] lim, lvx;
    logic          top, do_start, do_after, do_close, do_aend, fl;
    logic [4:0]    h;
    logic [7:0]    c;
    logic [15:0]   code;
    mode_next      = mode;
    level_next     = level;
    esc_code_next  = esc_code;
    hex_count_next = hex_count;
    lit_kind_next  = lit_kind;
    lit_pos_next   = lit_pos;
    in_key_next    = in_key;
    do_push = 1'b0; do_pop = 1'b0; push_kind = 1'b0;
    bnd = '0;
    bnd.ev = '{default: '{kind: EV_OBJ_OPEN, data: 8'd0, level: 8'd0, code: ER_DEPTH}};
    c = text_byte;
    top = stk[0];
    do_start = 1'b0; do_after = 1'b0; do_close = 1'b0; do_aend = 1'b0;
    lim = (CW'(max_depth) < CW'(MAX_NEST)) ? CW'(max_depth) : CW'(MAX_NEST);
    h = hex_val(c);
    code = 16'd0;
    fl = 1'b0;
    lvx = '0;

    if (byte_valid) begin
      case (mode_next)
        MD_TOP, MD_VALUE: if (!is_ws(c)) do_start = 1'b1;
        MD_ARR_FIRST: if (!is_ws(c)) begin
          if (c == "]") do_close = 1'b1;
          else do_start = 1'b1;
        end
        MD_OBJ_FIRST, MD_KEY_NEXT: if (!is_ws(c)) begin
          if (c == "}" && mode_next == MD_OBJ_FIRST) do_close = 1'b1;
          else if (c == "\"") begin
            in_key_next = 1'b1;
            mode_next = MD_STR;
          end else begin
            bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_KEY);
            mode_next = MD_ERR;
          end
        end
        MD_STR: begin
          if (c == "\"") begin
            bnd = add_ev(bnd, in_key_next ? EV_KEY_END : EV_STR_END, 8'd0, level_next,
                         ER_DEPTH);
            mode_next = in_key_next ? MD_COLON : MD_AFTER;
            in_key_next = 1'b0;
          end else if (c == "\\") mode_next = MD_ESC;
          else bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE, c, level_next,
                            ER_DEPTH);
        end
        MD_ESC: begin
          mode_next = MD_STR;
          case (c)
            "\"", "\\", "/": code = {8'd0, c};
            "b": code = 16'h0008;
            "f": code = 16'h000C;
            "n": code = 16'h000A;
            "r": code = 16'h000D;
            "t": code = 16'h0009;
            "u": begin
              esc_code_next = 16'd0;
              hex_count_next = 3'd0;
              mode_next = MD_HEX;
            end
            default: begin
              bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_BAD_ESC);
              mode_next = MD_ERR;
            end
          endcase
          if (mode_next == MD_STR)
            bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE, code[7:0],
                         level_next, ER_DEPTH);
        end
        MD_HEX: begin
          if (!h[4]) begin
            bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_BAD_HEX);
            mode_next = MD_ERR;
          end else begin
            esc_code_next = {esc_code[11:0], h[3:0]};
            hex_count_next = hex_count + 3'd1;
            if (hex_count_next >= 3'd4) begin
              code = esc_code_next;
              // Encode the code point as UTF-8
              if (code < 16'h0080) begin
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE, code[7:0],
                             level_next, ER_DEPTH);
              end else if (code < 16'h0800) begin
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE,
                             8'hC0 | {3'd0, code[10:6]}, level_next, ER_DEPTH);
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE,
                             8'h80 | {2'd0, code[5:0]}, level_next, ER_DEPTH);
              end else begin
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE,
                             8'hE0 | {4'd0, code[15:12]}, level_next, ER_DEPTH);
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE,
                             8'h80 | {2'd0, code[11:6]}, level_next, ER_DEPTH);
                bnd = add_ev(bnd, in_key_next ? EV_KEY_BYTE : EV_STR_BYTE,
                             8'h80 | {2'd0, code[5:0]}, level_next, ER_DEPTH);
              end
              hex_count_next = 3'd0;
              mode_next = MD_STR;
            end
          end
        end
        MD_COLON: if (!is_ws(c)) begin
          if (c == ":") mode_next = MD_VALUE;
          else begin
            bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_NO_COLON);
            mode_next = MD_ERR;
          end
        end
        MD_NUM: begin
          if (is_num(c)) bnd = add_ev(bnd, EV_NUM_BYTE, c, level_next, ER_DEPTH);
          else begin
            bnd = add_ev(bnd, EV_NUM_END, 8'd0, level_next, ER_DEPTH);
            mode_next = MD_AFTER;
            do_after = 1'b1;
          end
        end
        MD_LIT: begin
          if (lit_pos < lit_len(lit_kind) && c == lit_char(lit_kind, lit_pos)) begin
            lit_pos_next = lit_pos + 3'd1;
            if (lit_pos_next >= lit_len(lit_kind)) begin
              bnd = add_ev(bnd, (lit_kind == 2'd0) ? EV_TRUE :
                           (lit_kind == 2'd1) ? EV_FALSE : EV_NULL,
                           8'd0, level_next, ER_DEPTH);
              lit_pos_next = 3'd0;
              mode_next = MD_AFTER;
            end
          end else begin
            bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_LITERAL);
            mode_next = MD_ERR;
          end
        end
        MD_AFTER: do_after = 1'b1;
        default: ;
      endcase

      if (do_start) begin
        lvx = CW'(level_next);
        if (lvx > lim) begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_DEPTH);
          mode_next = MD_ERR;
        end else if (c == "{" || c == "[") begin
          push_kind = (c == "[");
          bnd = add_ev(bnd, push_kind ? EV_ARR_OPEN : EV_OBJ_OPEN, 8'd0, level_next,
                       ER_DEPTH);
          do_push = 1'b1;
          top = push_kind;
          level_next = level_next + LVL_W'(1);
          mode_next = push_kind ? MD_ARR_FIRST : MD_OBJ_FIRST;
        end else if (c == "\"") begin
          in_key_next = 1'b0;
          mode_next = MD_STR;
        end else if (c == "t" || c == "f" || c == "n") begin
          lit_kind_next = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
          lit_pos_next = 3'd1;
          mode_next = MD_LIT;
        end else if (is_num(c)) begin
          bnd = add_ev(bnd, EV_NUM_BYTE, c, level_next, ER_DEPTH);
          mode_next = MD_NUM;
        end else begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_BAD_START);
          mode_next = MD_ERR;
        end
      end

      if (do_after && !is_ws(c)) begin
        if (level_next == '0) begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_TRAILING);
          mode_next = MD_ERR;
        end else if (c == ",") mode_next = top ? MD_VALUE : MD_KEY_NEXT;
        else if ((top && c == "]") || (!top && c == "}")) do_close = 1'b1;
        else begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, top ? ER_ARR_SEP : ER_OBJ_SEP);
          mode_next = MD_ERR;
        end
      end

      if (do_close && level_next != '0) begin
        level_next = level_next - LVL_W'(1);
        bnd = add_ev(bnd, top ? EV_ARR_CLOSE : EV_OBJ_CLOSE, 8'd0, level_next, ER_DEPTH);
        do_pop = 1'b1;
        top = stk[1];
        mode_next = MD_AFTER;
      end
    end

    if (end_of_text) begin
      lvx = CW'(level_next);
      case (mode_next)
        MD_TOP, MD_VALUE, MD_ARR_FIRST: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next,
                       (lvx > lim) ? ER_DEPTH : ER_EARLY_END);
          mode_next = MD_ERR;
        end
        MD_OBJ_FIRST, MD_KEY_NEXT: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_KEY);
          mode_next = MD_ERR;
        end
        MD_STR, MD_ESC: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_UNTERM);
          mode_next = MD_ERR;
        end
        MD_HEX: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_TRUNC_U);
          mode_next = MD_ERR;
        end
        MD_COLON: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_NO_COLON);
          mode_next = MD_ERR;
        end
        MD_NUM: begin
          bnd = add_ev(bnd, EV_NUM_END, 8'd0, level_next, ER_DEPTH);
          do_aend = 1'b1;
        end
        MD_LIT: begin
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, ER_LITERAL);
          mode_next = MD_ERR;
        end
        MD_AFTER: do_aend = 1'b1;
        default: ;
      endcase
      if (do_aend) begin
        if (level_next == '0) begin
          bnd = add_ev(bnd, EV_DONE, 8'd0, level_next, ER_DEPTH);
          mode_next = MD_DONE;
        end else begin
          fl = top;
          bnd = add_ev(bnd, EV_ERROR, 8'd0, level_next, fl ? ER_ARR_SEP : ER_OBJ_SEP);
          mode_next = MD_ERR;
        end
      end
    end
  end

  assign q_push = accept && (bnd.cnt != 3'd0);
  assign q_data = bnd;

  // Nesting stack: top of stack sits in bit 0
  always_ff @(posedge clk) begin
    if (accept && do_push) stk <= {stk[SLOTS-2:0], push_kind};
    else if (accept && do_pop) stk <= {1'b0, stk[SLOTS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MD_TOP;
      level     <= '0;
      esc_code  <= '0;
      hex_count <= '0;
      lit_kind  <= '0;
      lit_pos   <= '0;
      in_key    <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      level     <= level_next;
      esc_code  <= esc_code_next;
      hex_count <= hex_count_next;
      lit_kind  <= lit_kind_next;
      lit_pos   <= lit_pos_next;
      in_key    <= in_key_next;
    end
  end

endmodule

/* hw/rtl/jst_queue.sv */
// Short bundle queue between the front end and the output serializer.
module jst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jst_pkg::bundle_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output jst_pkg::bundle_t rdata
);
  import jst_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  bundle_t         mem [QDEPTH];
  logic [PW-1:0]   wptr, rptr;
  logic [PW:0]     count;

  assign full     = (count == (PW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* hw/rtl/jst_back.sv */
// Back end: takes bundles off the queue and hands out one event per cycle while out_stall is low.
module jst_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  jst_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output jst_pkg::event_t  ev,
  output logic             last
);
  import jst_pkg::*;

  bundle_t    cur;
  logic       held;
  logic [1:0] idx;
  logic       done_cur;

  assign out_valid = held;
  assign ev        = cur.ev[idx];
  assign last      = ({1'b0, idx} == cur.cnt - 3'd1);
  assign done_cur  = !held || (!out_stall && last);
  assign q_pop     = done_cur && q_nonempty;

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else if (done_cur) begin
      held <= q_nonempty;
      idx  <= '0;
    end else if (!out_stall) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
